// ===== rtl/core/mted_pkg.sv =====
// Shared constants, configuration register codes and the control structs
// of the multi-tap echo delay. No dependencies; every other file imports it.
`default_nettype none

package mted_pkg;

    // Sizing of the block.
    localparam int RING_DEPTH  = 131072;
    localparam int MAX_TAPS    = 8;
    localparam int SAMPLE_BITS = 16;

    // Ring addressing: an index, and a length that can hold the depth itself.
    localparam int PTR_BITS = $clog2(RING_DEPTH);
    localparam int LEN_BITS = PTR_BITS + 1;

    // Field widths of the configuration registers.
    localparam int DECAY_BITS     = 10;
    localparam int LAG_BITS       = 17;
    localparam int TAP_COUNT_BITS = 4;
    localparam int RLEN_BITS      = 18;
    localparam int CFG_DATA_BITS  = 18;
    localparam int CFG_INDEX_BITS = 3;

    // Register reset values.
    localparam int DECAY_RESET = 550;
    localparam int LAG_RESET   = 11300;
    localparam int TAPS_RESET  = 8;
    localparam int RLEN_RESET  = 131072;

    // Tap bookkeeping.
    localparam int TAPS_BITS    = $clog2(MAX_TAPS + 1);
    localparam int TAP_IDX_BITS = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TGT_BITS     = LAG_BITS + $clog2(MAX_TAPS);
    localparam int LAGCMP_BITS  = (TGT_BITS > LEN_BITS) ? TGT_BITS : LEN_BITS;

    // Gain is compounded per tap; with a decay of at most 1023 it stays
    // below 1500 over sixteen taps, so twelve bits hold it.
    localparam int GAIN_BITS = 12;
    localparam int PERMILLE  = 1000;
    localparam int PM_LOG    = $clog2(PERMILLE);

    // Division by 1000 through a rounded-up reciprocal. For a dividend below
    // 2^N a shift of N + 10 makes the quotient exact.
    localparam int GP_BITS      = GAIN_BITS + DECAY_BITS;
    localparam int G_SHIFT      = GP_BITS + PM_LOG;
    localparam int G_MUL_BITS   = G_SHIFT - (PM_LOG - 1);
    localparam int G_PROD_BITS  = GP_BITS + G_MUL_BITS;
    localparam logic [G_MUL_BITS-1:0] G_MUL =
        G_MUL_BITS'(((64'd1 << G_SHIFT) + PERMILLE - 1) / PERMILLE);

    localparam int EP_BITS      = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int MAG_BITS     = SAMPLE_BITS + GAIN_BITS - 1;
    localparam int E_SHIFT      = MAG_BITS + PM_LOG;
    localparam int E_MUL_BITS   = E_SHIFT - (PM_LOG - 1);
    localparam int E_PROD_BITS  = MAG_BITS + E_MUL_BITS;
    localparam int Q_BITS       = E_PROD_BITS - E_SHIFT;
    localparam logic [E_MUL_BITS-1:0] E_MUL =
        E_MUL_BITS'(((64'd1 << E_SHIFT) + PERMILLE - 1) / PERMILLE);

    // Accumulator: the input plus one quotient per tap, with a sign bit.
    localparam int ACC_BITS = Q_BITS + $clog2(MAX_TAPS) + 2;
    localparam logic signed [ACC_BITS-1:0] SAT_HI =
        ACC_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ENABLE      = 3'd0,
        CFG_DECAY       = 3'd1,
        CFG_FIRST_LAG   = 3'd2,
        CFG_LAG_STEP    = 3'd3,
        CFG_TAP_COUNT   = 3'd4,
        CFG_RING_LENGTH = 3'd5
    } cfg_index_t;

    // Decoded configuration as seen by the controller and the datapath.
    typedef struct packed {
        logic                  enable;
        logic [DECAY_BITS-1:0] decay;
        logic [LAG_BITS-1:0]   first_lag;
        logic [LAG_BITS-1:0]   lag_step;
        logic [TAPS_BITS-1:0]  taps;
        logic [LEN_BITS-1:0]   len;
        logic                  clear;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                    load;
        logic                    write_ring;
        logic                    tap_a;
        logic                    tap_b;
        logic                    mag_step;
        logic                    acc_step;
        logic                    finish;
        logic [TAP_IDX_BITS-1:0] tap_idx;
    } cmd_t;

    // Ring length in use: zero acts as one, too large acts as the depth.
    function automatic logic [LEN_BITS-1:0] eff_len(input logic [RLEN_BITS-1:0] r);
        logic [31:0] w;
        w = 32'(r);
        if (w == 32'd0)
            return LEN_BITS'(1);
        else if (w > 32'(RING_DEPTH))
            return LEN_BITS'(RING_DEPTH);
        else
            return LEN_BITS'(w);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mted_cfg.sv =====
// Configuration register file of the multi-tap echo delay.
// Depends on mted_pkg; feeds decoded settings and a history clear pulse.
`default_nettype none

module mted_cfg
    import mted_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                           cfg
);

    logic                      enable_reg, enable_next;
    logic [DECAY_BITS-1:0]     decay_reg, decay_next;
    logic [LAG_BITS-1:0]       first_lag_reg, first_lag_next;
    logic [LAG_BITS-1:0]       lag_step_reg, lag_step_next;
    logic [TAP_COUNT_BITS-1:0] tap_count_reg, tap_count_next;
    logic [RLEN_BITS-1:0]      ring_length_reg, ring_length_next;
    logic                      clear;

    always_comb
    begin
        enable_next      = enable_reg;
        decay_next       = decay_reg;
        first_lag_next   = first_lag_reg;
        lag_step_next    = lag_step_reg;
        tap_count_next   = tap_count_reg;
        ring_length_next = ring_length_reg;
        clear            = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ENABLE:      enable_next = cfg_data[0];
                CFG_DECAY:       decay_next = cfg_data[DECAY_BITS-1:0];
                CFG_FIRST_LAG:
                begin
                    first_lag_next = cfg_data[LAG_BITS-1:0];
                    clear          = 1'b1;
                end
                CFG_LAG_STEP:
                begin
                    lag_step_next = cfg_data[LAG_BITS-1:0];
                    clear         = 1'b1;
                end
                CFG_TAP_COUNT:   tap_count_next = cfg_data[TAP_COUNT_BITS-1:0];
                CFG_RING_LENGTH: ring_length_next = cfg_data[RLEN_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            decay_reg       <= DECAY_BITS'(DECAY_RESET);
            first_lag_reg   <= LAG_BITS'(LAG_RESET);
            lag_step_reg    <= LAG_BITS'(LAG_RESET);
            tap_count_reg   <= TAP_COUNT_BITS'(TAPS_RESET);
            ring_length_reg <= RLEN_BITS'(RLEN_RESET);
        end
        else
        begin
            enable_reg      <= enable_next;
            decay_reg       <= decay_next;
            first_lag_reg   <= first_lag_next;
            lag_step_reg    <= lag_step_next;
            tap_count_reg   <= tap_count_next;
            ring_length_reg <= ring_length_next;
        end
    end

    // Tap counts beyond the hardware limit act as the limit.
    always_comb
    begin
        cfg.enable    = enable_reg;
        cfg.decay     = decay_reg;
        cfg.first_lag = first_lag_reg;
        cfg.lag_step  = lag_step_reg;
        cfg.taps      = (32'(tap_count_reg) > 32'(MAX_TAPS)) ? TAPS_BITS'(MAX_TAPS)
                                                             : TAPS_BITS'(tap_count_reg);
        cfg.len       = eff_len(ring_length_reg);
        cfg.clear     = clear;
    end

endmodule

`default_nettype wire

// ===== rtl/core/mted_ctrl.sv =====
// Controller of the multi-tap echo delay: sequences one transaction through
// the ring write, two steps per tap and the result register. Uses mted_pkg.
`default_nettype none

module mted_ctrl
    import mted_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_WRITE  = 7'b0000010,
        ST_TAP_A  = 7'b0000100,
        ST_TAP_B  = 7'b0001000,
        ST_DRAIN0 = 7'b0010000,
        ST_DRAIN1 = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [TAP_IDX_BITS-1:0] tap_idx_reg, tap_idx_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    ep_valid_reg;
    logic                    qm_valid_reg;
    logic                    last_tap;
    logic                    can_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign can_load  = !out_valid_reg || out_ready;
    assign last_tap  = (TAPS_BITS'(tap_idx_reg) + TAPS_BITS'(1)) == cfg.taps;

    always_comb
    begin
        state_next     = state_reg;
        tap_idx_next   = tap_idx_reg;
        cmd            = '0;
        cmd.tap_idx    = tap_idx_reg;
        cmd.mag_step   = ep_valid_reg;
        cmd.acc_step   = qm_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = cfg.enable ? ST_WRITE : ST_FINISH;
                end
            end
            ST_WRITE:
            begin
                cmd.write_ring = 1'b1;
                tap_idx_next   = '0;
                state_next     = (cfg.taps == '0) ? ST_FINISH : ST_TAP_A;
            end
            ST_TAP_A:
            begin
                cmd.tap_a  = 1'b1;
                state_next = ST_TAP_B;
            end
            ST_TAP_B:
            begin
                cmd.tap_b = 1'b1;
                if (last_tap)
                    state_next = ST_DRAIN0;
                else
                begin
                    tap_idx_next = tap_idx_reg + TAP_IDX_BITS'(1);
                    state_next   = ST_TAP_A;
                end
            end
            ST_DRAIN0: state_next = ST_DRAIN1;
            ST_DRAIN1: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (can_load)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            ep_valid_reg  <= 1'b0;
            qm_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_idx_reg   <= tap_idx_next;
            out_valid_reg <= out_valid_next;
            ep_valid_reg  <= cmd.tap_b;
            qm_valid_reg  <= ep_valid_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mted_dp.sv =====
// Datapath of the multi-tap echo delay: sample ring, tap pointers, gain
// chain, division by 1000 and the saturating accumulator. Uses mted_pkg.
`default_nettype none

module mted_dp
    import mted_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cfg_t                          cfg,
    input  wire cmd_t                          cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic signed [SAMPLE_BITS-1:0]      sample_out
);

    // Ring contents are valid below the high-water mark; everything at or above
    // it reads as zero, which stands in for clearing the memory.
    logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];

    logic [PTR_BITS-1:0]  wi_reg, wi_next;
    logic [LEN_BITS-1:0]  hw_reg, hw_next;
    logic [PTR_BITS-1:0]  tap_ptr_reg [MAX_TAPS];

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic [GAIN_BITS-1:0]          gain_reg;
    logic [TGT_BITS-1:0]           target_reg;
    logic [GP_BITS-1:0]            gp_reg;
    logic [SAMPLE_BITS-1:0]        rd_data_reg;
    logic                          rd_hit_reg;
    logic signed [EP_BITS-1:0]     ep_reg;
    logic                          neg_reg;
    logic [E_PROD_BITS-1:0]        qm_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;

    logic [PTR_BITS-1:0]           wi_eff;
    logic [LEN_BITS-1:0]           wi_inc;
    logic [PTR_BITS-1:0]           p_cur;
    logic [PTR_BITS-1:0]           p_fix;
    logic [LEN_BITS-1:0]           lag;
    logic                          lag_hit;
    logic [LEN_BITS-1:0]           p_inc;
    logic [PTR_BITS-1:0]           p_new;
    logic [G_PROD_BITS-1:0]        gq;
    logic signed [SAMPLE_BITS-1:0] rd_sample;
    logic signed [EP_BITS-1:0]     ep_next;
    logic [EP_BITS-1:0]            ep_abs;
    logic [MAG_BITS-1:0]           mag;
    logic [Q_BITS-1:0]             quot;
    logic signed [ACC_BITS-1:0]    term;
    logic signed [ACC_BITS-1:0]    sat;

    // Ring write position and high-water mark.
    always_comb
    begin
        wi_eff  = (LEN_BITS'(wi_reg) >= cfg.len) ? '0 : wi_reg;
        wi_inc  = LEN_BITS'(wi_eff) + LEN_BITS'(1);
        wi_next = (wi_inc >= cfg.len) ? '0 : wi_inc[PTR_BITS-1:0];
        hw_next = (wi_inc > hw_reg) ? wi_inc : hw_reg;
    end

    // Tap pointer update: a tap moves one entry once its lag has reached
    // its target, and wraps at the ring length.
    always_comb
    begin
        p_cur   = tap_ptr_reg[cmd.tap_idx];
        p_fix   = (LEN_BITS'(p_cur) >= cfg.len) ? '0 : p_cur;
        if (wi_reg >= p_fix)
            lag = LEN_BITS'(wi_reg) - LEN_BITS'(p_fix);
        else
            lag = cfg.len + LEN_BITS'(wi_reg) - LEN_BITS'(p_fix);
        lag_hit = LAGCMP_BITS'(lag) == LAGCMP_BITS'(target_reg);
        p_inc   = lag_hit ? LEN_BITS'(p_fix) + LEN_BITS'(1) : LEN_BITS'(p_fix);
        p_new   = (p_inc >= cfg.len) ? '0 : p_inc[PTR_BITS-1:0];
    end

    // Arithmetic: tap product, gain and magnitude times the reciprocal, the
    // signed quotient that truncates toward zero, and the saturation.
    always_comb
    begin
        gq        = G_PROD_BITS'(gp_reg) * G_PROD_BITS'(G_MUL);
        rd_sample = rd_hit_reg ? $signed(rd_data_reg) : '0;
        ep_next   = EP_BITS'(rd_sample) * EP_BITS'($signed({1'b0, gain_reg}));
        ep_abs    = ep_reg[EP_BITS-1] ? -ep_reg : ep_reg;
        mag       = ep_abs[MAG_BITS-1:0];
        quot      = qm_reg[E_SHIFT +: Q_BITS];
        term      = neg_reg ? -$signed(ACC_BITS'(quot)) : $signed(ACC_BITS'(quot));
        if (acc_reg > SAT_HI)
            sat = SAT_HI;
        else if (acc_reg < SAT_LO)
            sat = SAT_LO;
        else
            sat = acc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_ring)
            ring_mem[wi_eff] <= x_reg;
        if (cmd.tap_a)
            rd_data_reg <= ring_mem[p_new];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg <= '0;
            hw_reg <= '0;
            for (int i = 0; i < MAX_TAPS; i++)
                tap_ptr_reg[i] <= '0;
        end
        else if (cfg.clear)
        begin
            wi_reg <= '0;
            hw_reg <= '0;
            for (int i = 0; i < MAX_TAPS; i++)
                tap_ptr_reg[i] <= '0;
        end
        else
        begin
            if (cmd.write_ring)
            begin
                wi_reg <= wi_next;
                hw_reg <= hw_next;
            end
            if (cmd.tap_a)
                tap_ptr_reg[cmd.tap_idx] <= p_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg      <= sample_in;
            acc_reg    <= ACC_BITS'(sample_in);
            gain_reg   <= GAIN_BITS'(cfg.decay);
            target_reg <= TGT_BITS'(cfg.first_lag);
        end
        if (cmd.tap_a)
        begin
            rd_hit_reg <= LEN_BITS'(p_new) < hw_reg;
            gp_reg     <= GP_BITS'(gain_reg) * GP_BITS'(cfg.decay);
            target_reg <= target_reg + TGT_BITS'(cfg.lag_step);
        end
        if (cmd.tap_b)
        begin
            ep_reg   <= ep_next;
            gain_reg <= gq[G_SHIFT +: GAIN_BITS];
        end
        if (cmd.mag_step)
        begin
            neg_reg <= ep_reg[EP_BITS-1];
            qm_reg  <= E_PROD_BITS'(mag) * E_PROD_BITS'(E_MUL);
        end
        if (cmd.acc_step)
            acc_reg <= acc_reg + term;
        if (cmd.finish)
            sample_out_reg <= sat[SAMPLE_BITS-1:0];
    end

    assign sample_out = sample_out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/multi_tap_echo_delay.sv =====
// Top level of the multi-tap echo delay: register file, controller and
// datapath. Depends on mted_pkg, mted_cfg, mted_ctrl and mted_dp.
//
// Usage. Samples enter on the in_valid/in_ready channel (sample_in) and one
// echoed sample leaves per transaction on out_valid/out_ready (sample_out).
// Settings are written through cfg_we/cfg_index/cfg_data while no
// transaction is in flight; writing first_lag or lag_step empties the echo
// history, which takes effect at once with no clearing pass.
// Sequence. With echo enabled and at least one active tap, a transaction
// runs the ring write, then per tap a pointer update with ring read followed
// by the tap product, then drains the divide-by-1000 and accumulate stages,
// and finally loads the result. A new transaction is taken only once the
// previous one has loaded its result. The single ring read port and the
// per-tap gain recurrence keep the taps stepping one after another.
// With no active taps the ring write leads straight to the result load;
// with echo disabled the sample passes straight to the result load.
// Reset. Settings return to their defaults, the write index, tap pointers
// and history mark clear, and the ring reads as silence.
// Stalls. The result sits in an output register; a stalled receiver holds
// the next transaction in its last step until that register frees up.
`default_nettype none

module multi_tap_echo_delay
    import mted_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0]      sample_out
);

    cfg_t cfg;
    cmd_t cmd;

    // Register file; also produces the history clear on a lag write.
    mted_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer: owns the handshakes and steps the datapath per tap.
    mted_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Ring memory, tap pointers and the arithmetic.
    mted_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .sample_in  (sample_in),
        .sample_out (sample_out)
    );

endmodule

`default_nettype wire
